// ===== hw/rtl/pcva_pkg.sv =====
// Package for the per-CPU interrupt vector allocator.
// Holds the request and response types, operation and status codes, and the sequencer states.
// No dependencies.
package pcva_pkg;

    localparam int NUM_CPUS_DEF     = 8;
    localparam int FIRST_VECTOR_DEF = 64;
    localparam int WORD_W           = 64;
    localparam int BIT_W            = 6;
    localparam int WORDS_PER_CPU    = 4;
    localparam int WSEL_W           = 2;
    localparam int CPU_W            = 3;
    localparam int VEC_W            = 8;
    localparam int STATUS_W         = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IGNORED   = 2'd3;

    typedef struct packed {
        logic             op;
        logic [CPU_W-1:0] cpu_index;
        logic [VEC_W-1:0] vector_in;
    } t_req;

    typedef struct packed {
        logic [VEC_W-1:0]    vector_out;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE
    } t_state;

endpackage

// ===== hw/rtl/per_cpu_interrupt_vector_allocator_top.sv =====
// Per-CPU interrupt vector allocator: top level with the scan sequencer.
// Allocate scans the CPU's bitmap words from the lowest until one has a clear bit; a valid free
// clears one bit, and busy drops as the result strobes; a rejected request never raises busy.
// The shared find-first-zero unit and the single RAM read port set one word per cycle.
// After reset all NUM_CPUS*4 RAM words are written to load reserved vectors; busy is high then.
// Uses pcva_pkg, pcva_bitmap_ram and pcva_ffz.
module per_cpu_interrupt_vector_allocator_top #(
    parameter int NUM_CPUS     = pcva_pkg::NUM_CPUS_DEF,
    parameter int FIRST_VECTOR = pcva_pkg::FIRST_VECTOR_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  pcva_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output pcva_pkg::t_rsp o_rsp
);
    import pcva_pkg::*;

    localparam int DEPTH = NUM_CPUS * WORDS_PER_CPU;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [WORD_W-1:0] RESV_MASK =
        (FIRST_VECTOR >= WORD_W) ? {WORD_W{1'b1}}
                                 : ((WORD_W'(1) << FIRST_VECTOR) - WORD_W'(1));

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CPU_W-1:0]   r_cpu, n_cpu;
    logic [WSEL_W-1:0]  r_word, n_word;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               ffz_found;
    logic [BIT_W-1:0]   ffz_bit;
    logic               cpu_ok;
    logic               vec_ok;

    pcva_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    pcva_ffz u_ffz (
        .i_word  (rd_data),
        .o_found (ffz_found),
        .o_bit   (ffz_bit)
    );

    assign cpu_ok = ({1'b0, 8'(i_req.cpu_index)} < 9'(NUM_CPUS));
    assign vec_ok = (i_req.vector_in >= VEC_W'(FIRST_VECTOR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpu  <= n_cpu;
        r_word <= n_word;
        r_bit  <= n_bit;
        r_rsp  <= n_rsp;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cpu   = r_cpu;
        n_word  = r_word;
        n_bit   = r_bit;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        rd_en   = 1'b0;
        rd_addr = AW'({r_cpu, r_word});
        wr_en   = 1'b0;
        wr_addr = AW'({r_cpu, r_word});
        wr_data = rd_data;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr[WSEL_W-1:0] == '0) ? RESV_MASK : '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cpu  = i_req.cpu_index;
                    n_bit  = i_req.vector_in[BIT_W-1:0];
                    n_word = (i_req.op == OP_FREE) ? i_req.vector_in[VEC_W-1 -: WSEL_W] : '0;
                    rd_addr = AW'({i_req.cpu_index, n_word});
                    if (i_req.op == OP_ALLOC) begin
                        if (cpu_ok) begin
                            rd_en   = 1'b1;
                            n_state = S_ALLOC;
                        end else begin
                            n_done = 1'b1;
                            n_rsp  = '{vector_out: '0, status: STAT_NONE_FREE};
                        end
                    end else begin
                        if (cpu_ok && vec_ok) begin
                            rd_en   = 1'b1;
                            n_state = S_FREE;
                        end else begin
                            n_done = 1'b1;
                            n_rsp  = '{vector_out: '0, status: STAT_IGNORED};
                        end
                    end
                end
            end
            S_ALLOC: begin
                if (ffz_found) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data | (WORD_W'(1) << ffz_bit);
                    n_done  = 1'b1;
                    n_rsp   = '{vector_out: {r_word, ffz_bit}, status: STAT_ALLOCATED};
                    n_state = S_IDLE;
                end else if (r_word == '1) begin
                    n_done  = 1'b1;
                    n_rsp   = '{vector_out: '0, status: STAT_NONE_FREE};
                    n_state = S_IDLE;
                end else begin
                    n_word  = r_word + WSEL_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = AW'({r_cpu, n_word});
                end
            end
            S_FREE: begin
                wr_en   = 1'b1;
                wr_data = rd_data & ~(WORD_W'(1) << r_bit);
                n_done  = 1'b1;
                n_rsp   = '{vector_out: '0, status: STAT_FREED};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== hw/rtl/pcva_bitmap_ram.sv =====
// Bitmap storage for the vector allocator: one write port and one registered read port.
// Depends on pcva_pkg for the word width.
module pcva_bitmap_ram #(
    parameter int DEPTH = pcva_pkg::NUM_CPUS_DEF * pcva_pkg::WORDS_PER_CPU,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [pcva_pkg::WORD_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [pcva_pkg::WORD_W-1:0] i_wr_data
);
    import pcva_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/pcva_ffz.sv =====
// Find-first-zero unit: returns the position of the lowest clear bit of one bitmap word.
// Depends on pcva_pkg for the word and bit-index widths.
module pcva_ffz (
    input  logic [pcva_pkg::WORD_W-1:0] i_word,
    output logic                        o_found,
    output logic [pcva_pkg::BIT_W-1:0]  o_bit
);
    import pcva_pkg::*;

    always_comb begin
        o_found = 1'b0;
        o_bit   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_found = 1'b1;
                o_bit   = BIT_W'(i);
            end
        end
    end

endmodule

// ===== test/per_cpu_interrupt_vector_allocator_top_test.sv =====
// Testbench for the per-CPU interrupt vector allocator top level.
// Directed table then random allocate/free traffic, checked against an in-bench occupancy model.
// Depends on pcva_pkg and per_cpu_interrupt_vector_allocator_top.
`timescale 1ns / 100ps

module per_cpu_interrupt_vector_allocator_top_test;
    import pcva_pkg::*;

    localparam int NCPU    = NUM_CPUS_DEF;
    localparam int FIRST_V = FIRST_VECTOR_DEF;
    localparam int NWORDS  = NCPU * WORDS_PER_CPU;
    localparam int N_DIR   = 23;
    localparam int N_SEG   = 7;
    localparam int SEG_LEN = 236;

    typedef struct packed {
        t_req req;
        logic chk;
        t_rsp rsp;
    } t_row;

    localparam t_row DIR_TAB [0:N_DIR-1] = '{
        '{'{OP_ALLOC, 3'd0, 8'd0},   1'b1, '{8'd64, STAT_ALLOCATED}},
        '{'{OP_ALLOC, 3'd0, 8'd255}, 1'b1, '{8'd65, STAT_ALLOCATED}},
        '{'{OP_ALLOC, 3'd7, 8'd0},   1'b1, '{8'd64, STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd0, 8'd0},   1'b1, '{8'd0,  STAT_IGNORED}},
        '{'{OP_FREE,  3'd0, 8'd63},  1'b1, '{8'd0,  STAT_IGNORED}},
        '{'{OP_FREE,  3'd0, 8'd64},  1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_ALLOC, 3'd0, 8'd170}, 1'b1, '{8'd64, STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd0, 8'd255}, 1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_FREE,  3'd7, 8'd128}, 1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_FREE,  3'd3, 8'd65},  1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_ALLOC, 3'd3, 8'd0},   1'b1, '{8'd64, STAT_ALLOCATED}},
        '{'{OP_ALLOC, 3'd3, 8'd0},   1'b1, '{8'd65, STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd3, 8'd64},  1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_ALLOC, 3'd1, 8'd85},  1'b1, '{8'd64, STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd0, 8'd66},  1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_ALLOC, 3'd0, 8'd0},   1'b1, '{8'd66, STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd0, 8'd65},  1'b0, '{8'd0,  STAT_ALLOCATED}},
        '{'{OP_ALLOC, 3'd0, 8'd0},   1'b0, '{8'd0,  STAT_ALLOCATED}},
        '{'{OP_ALLOC, 3'd3, 8'd0},   1'b0, '{8'd0,  STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd6, 8'd127}, 1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_FREE,  3'd2, 8'd192}, 1'b1, '{8'd0,  STAT_FREED}},
        '{'{OP_ALLOC, 3'd2, 8'd0},   1'b0, '{8'd0,  STAT_ALLOCATED}},
        '{'{OP_FREE,  3'd4, 8'd1},   1'b1, '{8'd0,  STAT_IGNORED}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    logic [WORD_W-1:0] vec_map [NWORDS];
    t_rsp pending_rsp [$];
    int errors = 0;
    int n_alloc = 0;
    int n_none_free = 0;
    int n_freed = 0;
    int n_ignored = 0;

    per_cpu_interrupt_vector_allocator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int idx;
        bit found;
        rsp.vector_out = '0;
        found = 1'b0;
        if (r.op == OP_ALLOC) begin
            rsp.status = STAT_NONE_FREE;
            if (int'(r.cpu_index) < NCPU) begin
                for (int w = 0; w < WORDS_PER_CPU; w++) begin
                    idx = int'(r.cpu_index) * WORDS_PER_CPU + w;
                    for (int b = 0; b < WORD_W; b++) begin
                        if (!found && !vec_map[idx][b]) begin
                            found = 1'b1;
                            vec_map[idx][b] = 1'b1;
                            rsp.vector_out = VEC_W'(w * WORD_W + b);
                            rsp.status = STAT_ALLOCATED;
                        end
                    end
                end
            end
        end else begin
            rsp.status = STAT_IGNORED;
            if (int'(r.cpu_index) < NCPU && int'(r.vector_in) >= FIRST_V) begin
                idx = int'(r.cpu_index) * WORDS_PER_CPU + int'(r.vector_in[VEC_W-1:BIT_W]);
                vec_map[idx][r.vector_in[BIT_W-1:0]] = 1'b0;
                rsp.status = STAT_FREED;
            end
        end
        return rsp;
    endfunction

    function automatic logic [VEC_W-1:0] pick_taken(input int cpu);
        int v;
        v = $urandom_range(FIRST_V, 255);
        for (int k = 0; k < 256; k++) begin
            if (vec_map[cpu * WORDS_PER_CPU + v / WORD_W][v % WORD_W])
                return VEC_W'(v);
            v = (v == 255) ? FIRST_V : v + 1;
        end
        return VEC_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_req r, input int gap, input logic chk, input t_rsp typed);
        t_rsp predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_request(r);
        pending_rsp.push_back(chk ? typed : predicted);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result: vector_out %0d status %0d",
                       o_rsp.vector_out, o_rsp.status);
                errors++;
            end else begin
                if (o_rsp.vector_out !== pending_rsp[0].vector_out) begin
                    $error("vector_out: expected %0d, got %0d",
                           pending_rsp[0].vector_out, o_rsp.vector_out);
                    errors++;
                end
                if (o_rsp.status !== pending_rsp[0].status) begin
                    $error("status: expected %0d, got %0d",
                           pending_rsp[0].status, o_rsp.status);
                    errors++;
                end
                void'(pending_rsp.pop_front());
            end
            case (o_rsp.status)
                STAT_ALLOCATED: n_alloc++;
                STAT_NONE_FREE: n_none_free++;
                STAT_FREED:     n_freed++;
                default:        n_ignored++;
            endcase
        end
    end

    initial begin
        t_req r;
        int hot_cpu;
        int alloc_pct;
        int sel;
        bit no_idle;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        for (int i = 0; i < NWORDS; i++)
            vec_map[i] = (i % WORDS_PER_CPU == 0)
                       ? ((FIRST_V >= WORD_W) ? '1 : ((WORD_W'(1) << FIRST_V) - 1))
                       : '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_item(DIR_TAB[i].req, pick_gap(1'b0), DIR_TAB[i].chk, DIR_TAB[i].rsp);

        // Even segments push one CPU to exhaustion; odd ones drain with mixed traffic.
        for (int s = 0; s < N_SEG; s++) begin
            hot_cpu = $urandom_range(0, NCPU - 1);
            alloc_pct = (s % 2 == 0) ? 98 : $urandom_range(20, 60);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < SEG_LEN; i++) begin
                r.cpu_index = ($urandom_range(0, 99) < 90) ? CPU_W'(hot_cpu)
                                                         : CPU_W'($urandom_range(0, 7));
                r.vector_in = VEC_W'($urandom_range(0, 255));
                r.op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
                if (r.op == OP_FREE) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                        r.vector_in = VEC_W'($urandom_range(0, FIRST_V - 1));
                    else if (sel >= 20)
                        r.vector_in = pick_taken(int'(r.cpu_index));
                end
                send_item(r, pick_gap(no_idle), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Results: %0d allocated, %0d none free, %0d freed, %0d ignored.",
                 n_alloc, n_none_free, n_freed, n_ignored);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
